// ----- rtl/lru_page_replacement_assert.svh -----
// ----------------------------------------------------------------------------
// LRU page store assertion macros
// Concurrent checks on clk, with or without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTH

// Check on every clk edge while out of reset.
`define LRUPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clk edge, reset included.
`define LRUPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRUPR_ASSERT(label, prop, msg)
`define LRUPR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- rtl/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page store package
// Port widths, reset constants and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_W  = 16;   // width of the page and evicted_page ports
    localparam int CFG_W   = 3;    // width of the frame count register
    localparam int COUNT_W = 32;   // width of the fault total

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    // Control handed from the top level to each cell of the row
    typedef struct packed {
        logic en;          // request accepted this cycle
        logic live;        // cell holds a resident page
        logic at_tail;     // cell takes the referenced page
        logic below_tail;  // cell may shift from its upper neighbor
    } lrupr_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement, fully associative
// Row of recency cells with parallel compare and a shift-down chain.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive page and raise start; a request is taken at a
//   rising edge where start is high and busy is low. busy stays low, so a
//   new request may be presented in every cycle.
//   Result channel: done pulses for one cycle, in the cycle after the request
//   edge, with fault, evicted_valid, evicted_page and fault_total. The
//   receiver cannot stall; each result is valid only in its done cycle.
//   Throughput is one request per cycle. The work of a request is one
//   pass over the cell row: every cell compares its page at once, the hit
//   flag ripples up the row, and all cells shift or load at the same edge.
//   Configuration: cfg_we with cfg_data writes the frame count; 0 acts as
//   one frame and values above FRAMES act as FRAMES. Write it only while
//   no result is pending.
//   Reset: rst_n clears occupancy, the fault total and the result strobe,
//   and sets the frame count to 4. Cell contents are not cleared; cells at
//   or above the occupancy are never compared.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 4,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [PAGE_W-1:0]  page,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output logic                    done,
    output logic                    fault,
    output logic                    evicted_valid,
    output logic [PAGE_W-1:0]       evicted_page,
    output logic [COUNT_W-1:0]      fault_total
);

`include "lru_page_replacement_assert.svh"

    localparam int OCC_W = $clog2(FRAMES + 1);

    // Control and result registers
    logic [CFG_W-1:0]    cfg_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [COUNT_W-1:0]  fault_count_reg;
    logic [COUNT_W-1:0]  fault_count_next;
    logic                done_reg;
    logic                fault_reg;
    logic                ev_valid_reg;
    logic [PAGE_W-1:0]   ev_page_reg;

    logic                accept;
    logic [PAGE_BITS-1:0] page_key;
    logic [OCC_W-1:0]    cap;
    logic                hit;
    logic                evict;
    logic [OCC_W-1:0]    tail;

    logic [PAGE_BITS-1:0] entry_w [FRAMES];
    logic [FRAMES-1:0]    match_w;
    logic [FRAMES:0]      shift_w;
    lrupr_ctl_t           ctl_w [FRAMES];

    // The whole reference is handled in the cycle it is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Drop or zero-fill the upper page bits to the stored width
    assign page_key = PAGE_BITS'(page);

    // Effective frame count: clamp the register into 1..FRAMES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cap = OCC_W'(1);
        end
        else if (int'(cfg_reg) > FRAMES)
        begin
            cap = OCC_W'(FRAMES);
        end
        else
        begin
            cap = OCC_W'(cfg_reg);
        end
    end

    // Pages in the row are unique, so at most one cell matches
    assign hit   = |match_w;
    // A miss with no free frame evicts the least recent page from cell 0
    assign evict = !hit && (occ_reg >= cap);
    // A miss with a free frame appends at the occupancy; otherwise the
    // referenced page lands in the top live cell
    assign tail  = (!hit && !evict) ? occ_reg : occ_reg - OCC_W'(1);

    assign shift_w[0] = evict;

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            logic [PAGE_BITS-1:0] upper;

            if (gi == FRAMES - 1)
            begin : g_top
                assign upper = page_key;
            end
            else
            begin : g_mid
                assign upper = entry_w[gi+1];
            end

            assign ctl_w[gi].en         = accept;
            assign ctl_w[gi].live       = OCC_W'(gi) < occ_reg;
            assign ctl_w[gi].at_tail    = OCC_W'(gi) == tail;
            assign ctl_w[gi].below_tail = OCC_W'(gi) < tail;

            lrupr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl_w[gi]),
                .page_in   (page_key),
                .neighbor  (upper),
                .shift_in  (shift_w[gi]),
                .entry     (entry_w[gi]),
                .match     (match_w[gi]),
                .shift_out (shift_w[gi+1])
            );
        end
    endgenerate

    // Occupancy grows only on an append; fault total saturates
    always_comb
    begin
        occ_next         = occ_reg;
        fault_count_next = fault_count_reg;
        if (accept && !hit)
        begin
            if (!evict)
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
            if (fault_count_reg != '1)
            begin
                fault_count_next = fault_count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= CFG_RESET;
            occ_reg         <= '0;
            fault_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            occ_reg         <= occ_next;
            fault_count_reg <= fault_count_next;
            done_reg        <= accept;
        end
    end

    // Hold the result fields of the last request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fault_reg    <= !hit;
            ev_valid_reg <= evict;
            ev_page_reg  <= evict ? PAGE_W'(entry_w[0]) : '0;
        end
    end

    assign done          = done_reg;
    assign fault         = fault_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_total   = fault_count_reg;

    `LRUPR_ASSERT(a_occ_bound, occ_reg <= OCC_W'(FRAMES), "occupancy above frame count")
    `LRUPR_ASSERT(a_done_follows, done_reg == $past(accept && rst_n), "done without request")
    `LRUPR_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `LRUPR_ASSERT(a_empty_faults, accept && (occ_reg == '0) |=> fault, "hit reported on empty store")
    `LRUPR_ASSERT(a_hit_no_count, done && !fault |-> $stable(fault_total), "fault total moved on hit")
    `LRUPR_ASSERT(a_evict_is_fault, done && evicted_valid |-> fault, "eviction on hit")

endmodule

`default_nettype wire

// ----- rtl/lrupr_cell.sv -----
// ----------------------------------------------------------------------------
// LRU page store cell
// One recency slot: compares its page, ripples the shift flag, shifts down.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire lrupr_ctl_t           ctl,
    input  wire logic [PAGE_BITS-1:0] page_in,
    input  wire logic [PAGE_BITS-1:0] neighbor,
    input  wire logic                 shift_in,
    output logic      [PAGE_BITS-1:0] entry,
    output logic                      match,
    output logic                      shift_out
);

    logic [PAGE_BITS-1:0] entry_reg;
    logic [PAGE_BITS-1:0] entry_next;

    assign match     = ctl.live && (entry_reg == page_in);
    // From a hit (or cell 0 on an eviction) upward the flag is set; slots below the tail shift down
    assign shift_out = shift_in || match;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.en && ctl.at_tail)
        begin
            entry_next = page_in;
        end
        else if (ctl.en && shift_out && ctl.below_tail)
        begin
            entry_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- bench/lru_page_replacement_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page store checker
// Watches the request, result and frame-count channels. Keeps its own
// recency list and fault total, predicts each result and compares it field
// by field, and reports the mismatch count to the testbench top.
// ----------------------------------------------------------------------------
module lru_page_replacement_checker
    import lrupr_pkg::*;
#(
    parameter int FRAMES = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [PAGE_W-1:0]  page,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               done,
    input  wire logic               fault,
    input  wire logic               evicted_valid,
    input  wire logic [PAGE_W-1:0]  evicted_page,
    input  wire logic [COUNT_W-1:0] fault_total,
    output int                      mismatches,
    output int                      pending,
    output int                      hits_seen,
    output int                      faults_seen,
    output int                      evictions_seen
);

    typedef struct packed {
        logic               fault;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] total;
    } page_outcome_t;

    logic [PAGE_W-1:0]  lru_pages [FRAMES];
    int                 resident;
    logic [COUNT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frame_limit;
    page_outcome_t      outcome_q [$];

    assign pending = outcome_q.size();

    // Apply one reference to the recency list and return its outcome.
    task automatic touch_page(input logic [PAGE_W-1:0] p, output page_outcome_t r);
        int cap;
        int hit_pos;
        cap = (frame_limit == '0) ? 1 : ((int'(frame_limit) > FRAMES) ? FRAMES
                                                                     : int'(frame_limit));
        hit_pos = -1;
        r = '0;
        for (int i = 0; i < resident; i++)
            if (hit_pos < 0 && lru_pages[i] == p)
                hit_pos = i;
        if (hit_pos >= 0)
        begin
            for (int i = hit_pos; i < resident - 1; i++)
                lru_pages[i] = lru_pages[i + 1];
            lru_pages[resident - 1] = p;
        end
        else
        begin
            r.fault = 1'b1;
            if (resident < cap)
            begin
                lru_pages[resident] = p;
                resident++;
            end
            else
            begin
                r.ev_valid = 1'b1;
                r.ev_page  = lru_pages[0];
                for (int i = 0; i < resident - 1; i++)
                    lru_pages[i] = lru_pages[i + 1];
                lru_pages[resident - 1] = p;
            end
            if (fault_tally != '1)
                fault_tally++;
        end
        r.total = fault_tally;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        page_outcome_t want;
        page_outcome_t got;
        if (!rst_n)
        begin
            resident       = 0;
            fault_tally    = '0;
            frame_limit    = CFG_RESET;
            outcome_q.delete();
            mismatches     = 0;
            hits_seen      = 0;
            faults_seen    = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{fault, evicted_valid, evicted_page, fault_total};
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result fault=%0b ev=%0b/%h total=%0d",
                                 $time, fault, evicted_valid, evicted_page, fault_total);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp %0b/%0b/%h/%0d got %0b/%0b/%h/%0d",
                                     $time, want.fault, want.ev_valid, want.ev_page,
                                     want.total, got.fault, got.ev_valid, got.ev_page,
                                     got.total);
                    end
                end
            end
            if (cfg_we)
                frame_limit = cfg_data;
            if (start && !busy)
            begin
                touch_page(page, want);
                outcome_q.push_back(want);
                if (want.fault)
                    faults_seen++;
                else
                    hits_seen++;
                if (want.ev_valid)
                    evictions_seen++;
            end
        end
    end

endmodule

// ----- bench/tb_lru_page_replacement.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page store testbench
// Drives page references through the one-per-cycle request channel, moves
// the frame count between idle phases (extremes and out-of-range values
// included), and lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int FRAMES       = 4;
    localparam int RANDOM_ITEMS = 950;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic [PAGE_W-1:0]  page     = '0;
    logic               cfg_we   = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               busy;
    logic               done;
    logic               fault;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;

    int mismatches;
    int pending;
    int hits_seen;
    int faults_seen;
    int evictions_seen;
    int settings_used = 0;

    // Working set for the random part: a small window of pages so that
    // references hit often and evictions keep cycling through the list.
    logic [PAGE_W-1:0] hot_base = '0;

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .fault         (fault),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    lru_page_replacement_checker #(.FRAMES(FRAMES)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .page           (page),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .fault          (fault),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_total    (fault_total),
        .mismatches     (mismatches),
        .pending        (pending),
        .hits_seen      (hits_seen),
        .faults_seen    (faults_seen),
        .evictions_seen (evictions_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #500us;
        $display("TB_ERROR");
        $finish;
    end

    // Present one request and hold it until taken; then optionally drop
    // start for the given gap. With no gap start stays high, so the next
    // request follows back to back.
    task automatic issue_page(input logic [PAGE_W-1:0] p, input int gap);
        start <= 1'b1;
        page  <= p;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain the result channel, then write the frame count while idle.
    task automatic set_frame_count(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // leave a little margin before the write
        repeat (2) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Mostly the hot window, some extremes, the rest fully random.
    function automatic logic [PAGE_W-1:0] pick_page();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return hot_base + PAGE_W'($urandom_range(0, 5));
        if (roll < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(PAGE_W-1){1'b0}}};
                default: return {1'b0, {(PAGE_W-1){1'b1}}};
            endcase
        end
        return PAGE_W'($urandom);
    endfunction

    // Sender idle pattern: 16 in 100 first, then 50 in 100, then none.
    function automatic int pick_gap(input int item);
        int pct;
        if (item < RANDOM_ITEMS / 3)
            pct = 16;
        else if (item < (2 * RANDOM_ITEMS) / 3)
            pct = 50;
        else
            pct = 0;
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    initial
    begin
        logic [PAGE_W-1:0] fill_refs [9];
        logic [CFG_W-1:0]  phase_frames [10];
        int                item;
        int                per_phase;

        // Fill the list, hit at the least-recent end and in the middle, evict twice.
        fill_refs = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002,
                      16'h0003, 16'h0000, 16'h0003, 16'h0004};
        phase_frames = '{3'd3, 3'd1, 3'd2, 3'd4, 3'd6, 3'd0, 3'd5, 3'd7, 3'd2, 3'd4};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seven acts as four: occupancy should stop growing at four.
        set_frame_count(3'd7);
        foreach (fill_refs[i])
            issue_page(fill_refs[i], i % 3);

        // Zero acts as one while four pages stay resident: a hit on the least-recent page,
        // two misses that evict without shrinking, then a hit on the new least-recent page.
        set_frame_count(3'd0);
        issue_page(16'h0002, 0);
        issue_page(16'hAAAA, 0);
        issue_page(16'h5555, 1);
        issue_page(16'h0004, 0);

        // Back to the full row.
        set_frame_count(3'd4);
        issue_page(16'h0004, 0);
        issue_page(16'h1234, 0);
        issue_page(16'h5555, 2);
        issue_page(16'hEDCB, 0);

        // Random part, split over the frame-count settings.
        per_phase = RANDOM_ITEMS / $size(phase_frames);
        item = 0;
        foreach (phase_frames[ph])
        begin
            set_frame_count(phase_frames[ph]);
            hot_base = PAGE_W'($urandom);
            for (int n = 0; n < per_phase || (ph == $size(phase_frames) - 1 &&
                                              item < RANDOM_ITEMS); n++)
            begin
                // shift the window now and then so old pages age out
                if ($urandom_range(0, 39) == 0)
                    hot_base = hot_base + PAGE_W'($urandom_range(1, 4));
                issue_page(pick_page(), pick_gap(item));
                item++;
            end
        end

        // Drain: every request answered, then a short wait for strays.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d page references: %0d hits, %0d faults, %0d evictions,",
                 hits_seen + faults_seen, hits_seen, faults_seen, evictions_seen);
        $display("over %0d frame-count writes including 0 and 7; %0d mismatches.",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
